/* rtl/nm_pkg.sv */
package nm_pkg;

    localparam int NUM_ENTRIES = 9;
    localparam int THR_W       = 31;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index taken from paddr[2]
    localparam logic REG_DET_THRESHOLD = 1'b0;

    typedef struct packed {
        logic valid;
        logic singular;
    } t_stage_ctl;

    // remainder width of the divider chain: holds |cof| << 2F and |det| << DW
    function automatic int rem_width(input int dw, input int f);
        int nw;
        int dw_sh;
        nw    = 2 * dw + 1 + 2 * f;
        dw_sh = 4 * dw + 3;
        return ((nw > dw_sh) ? nw : dw_sh) + 1;
    endfunction

endpackage

/* rtl/nm_in_if.sv */
interface nm_in_if #(parameter int DW = 32);
    logic              valid;
    logic              ready;
    logic signed [DW-1:0] col0_row0;
    logic signed [DW-1:0] col0_row1;
    logic signed [DW-1:0] col0_row2;
    logic signed [DW-1:0] col1_row0;
    logic signed [DW-1:0] col1_row1;
    logic signed [DW-1:0] col1_row2;
    logic signed [DW-1:0] col2_row0;
    logic signed [DW-1:0] col2_row1;
    logic signed [DW-1:0] col2_row2;

    modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, input ready);
    modport sink (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                  col1_row2, col2_row0, col2_row1, col2_row2, output ready);
endinterface

/* rtl/nm_out_if.sv */
interface nm_out_if #(parameter int DW = 32);
    logic              valid;
    logic              ready;
    logic signed [DW-1:0] out_c0_r0;
    logic signed [DW-1:0] out_c0_r1;
    logic signed [DW-1:0] out_c0_r2;
    logic signed [DW-1:0] out_c1_r0;
    logic signed [DW-1:0] out_c1_r1;
    logic signed [DW-1:0] out_c1_r2;
    logic signed [DW-1:0] out_c2_r0;
    logic signed [DW-1:0] out_c2_r1;
    logic signed [DW-1:0] out_c2_r2;
    logic              singular;

    modport source (output valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                    out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, input ready);
    modport sink (input valid, out_c0_r0, out_c0_r1, out_c0_r2, out_c1_r0, out_c1_r1,
                  out_c1_r2, out_c2_r0, out_c2_r1, out_c2_r2, singular, output ready);
endinterface

/* rtl/nm_front.sv */
module nm_front #(
    parameter int DW = 32,
    parameter int F  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic [nm_pkg::NUM_ENTRIES-1:0][DW-1:0] i_mat,
    input  logic [nm_pkg::THR_W-1:0] i_thr,
    input  logic i_en_down,
    output nm_pkg::t_stage_ctl o_ctl,
    output logic [3*DW+2:0] o_den,
    output logic [nm_pkg::NUM_ENTRIES-1:0][nm_pkg::rem_width(DW, F)-1:0] o_rem,
    output logic [nm_pkg::NUM_ENTRIES-1:0] o_neg,
    output logic [nm_pkg::NUM_ENTRIES-1:0] o_ovf
);
    import nm_pkg::*;

    localparam int PW  = 2 * DW;
    localparam int CW  = 2 * DW + 1;
    localparam int MW  = 2 * DW + 1;
    localparam int TW  = 3 * DW + 2;
    localparam int DTW = 3 * DW + 3;
    localparam int XW  = rem_width(DW, F);
    localparam int NS  = 7;

    logic [NS:0]   w_en;
    logic [NS-1:0] r_v;

    logic signed [DW-1:0] w_a [3][3];
    logic signed [PW-1:0] w_p [NUM_ENTRIES];
    logic signed [PW-1:0] w_q [NUM_ENTRIES];

    logic signed [PW-1:0] r_p [NUM_ENTRIES];
    logic signed [PW-1:0] r_q [NUM_ENTRIES];
    logic signed [DW-1:0] r_a0_s0 [3];
    logic signed [DW-1:0] r_a0_s1 [3];
    logic signed [CW-1:0] r_cof1 [NUM_ENTRIES];
    logic signed [CW-1:0] r_cof2 [NUM_ENTRIES];
    logic signed [CW-1:0] r_cof3 [NUM_ENTRIES];
    logic signed [CW-1:0] r_cof4 [NUM_ENTRIES];
    logic signed [MW-1:0] r_ml [3];
    logic signed [MW-1:0] r_mh [3];
    logic signed [TW-1:0] r_t [3];
    logic signed [DTW-1:0] r_det;
    logic [DTW-1:0] r_dmag;
    logic           r_dneg;
    logic [CW-1:0]  r_cmag [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_cneg;

    logic           r_sing;
    logic [DTW-1:0] r_den;
    logic [NUM_ENTRIES-1:0][XW-1:0] r_rem;
    logic [NUM_ENTRIES-1:0] r_neg;
    logic [NUM_ENTRIES-1:0] r_ovf;

    logic [NUM_ENTRIES-1:0][XW-1:0] n_rem;
    logic [NUM_ENTRIES-1:0] n_ovf;
    logic [XW-1:0] w_den_sh;
    logic          n_sing;

    // a stage loads when empty or when its item moves on
    always_comb begin
        w_en[NS] = i_en_down;
        for (int s = NS - 1; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign o_ready = w_en[0];

    genvar gr, gc;
    generate
        for (gr = 0; gr < 3; gr++) begin : g_row
            for (gc = 0; gc < 3; gc++) begin : g_col
                assign w_a[gr][gc] = i_mat[gc*3+gr];
                assign w_p[gr*3+gc] = w_a[(gr+1)%3][(gc+1)%3] * w_a[(gr+2)%3][(gc+2)%3];
                assign w_q[gr*3+gc] = w_a[(gr+1)%3][(gc+2)%3] * w_a[(gr+2)%3][(gc+1)%3];
            end
        end
    endgenerate

    always_comb begin
        w_den_sh = XW'(r_dmag) << DW;
        n_sing   = XW'(r_dmag) <= (XW'(i_thr) << (2 * F));
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            n_rem[i] = XW'(r_cmag[i]) << (2 * F);
            n_ovf[i] = n_rem[i] >= w_den_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_p[i] <= w_p[i];
                r_q[i] <= w_q[i];
            end
            for (int j = 0; j < 3; j++) begin
                r_a0_s0[j] <= w_a[0][j];
            end
        end
        if (w_en[1]) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_cof1[i] <= CW'(r_p[i]) - CW'(r_q[i]);
            end
            r_a0_s1 <= r_a0_s0;
        end
        if (w_en[2]) begin
            for (int j = 0; j < 3; j++) begin
                r_ml[j] <= r_a0_s1[j] * $signed({1'b0, r_cof1[j][DW-1:0]});
                r_mh[j] <= r_a0_s1[j] * $signed(r_cof1[j][CW-1:DW]);
            end
            r_cof2 <= r_cof1;
        end
        if (w_en[3]) begin
            for (int j = 0; j < 3; j++) begin
                r_t[j] <= (TW'(r_mh[j]) <<< DW) + TW'(r_ml[j]);
            end
            r_cof3 <= r_cof2;
        end
        if (w_en[4]) begin
            r_det  <= DTW'(r_t[0]) + DTW'(r_t[1]) + DTW'(r_t[2]);
            r_cof4 <= r_cof3;
        end
        if (w_en[5]) begin
            r_dneg <= r_det[DTW-1];
            r_dmag <= r_det[DTW-1] ? DTW'(-r_det) : DTW'(r_det);
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_cneg[i] <= r_cof4[i][CW-1];
                r_cmag[i] <= r_cof4[i][CW-1] ? CW'(-r_cof4[i]) : CW'(r_cof4[i]);
            end
        end
        if (w_en[6]) begin
            r_sing <= n_sing;
            r_den  <= r_dmag;
            r_rem  <= n_rem;
            r_ovf  <= n_ovf;
            r_neg  <= r_cneg ^ {NUM_ENTRIES{r_dneg}};
        end
    end

    assign o_ctl = '{valid: r_v[NS-1], singular: r_sing};
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_neg = r_neg;
    assign o_ovf = r_ovf;

endmodule

/* rtl/nm_div_cell.sv */
module nm_div_cell #(
    parameter int DW  = 32,
    parameter int F   = 16,
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  nm_pkg::t_stage_ctl i_ctl,
    input  logic i_en_down,
    output logic o_en,
    input  logic [3*DW+2:0] i_den,
    input  logic [nm_pkg::NUM_ENTRIES-1:0][nm_pkg::rem_width(DW, F)-1:0] i_rem,
    input  logic [nm_pkg::NUM_ENTRIES-1:0][DW-1:0] i_quo,
    input  logic [nm_pkg::NUM_ENTRIES-1:0] i_neg,
    input  logic [nm_pkg::NUM_ENTRIES-1:0] i_ovf,
    output nm_pkg::t_stage_ctl o_ctl,
    output logic [3*DW+2:0] o_den,
    output logic [nm_pkg::NUM_ENTRIES-1:0][nm_pkg::rem_width(DW, F)-1:0] o_rem,
    output logic [nm_pkg::NUM_ENTRIES-1:0][DW-1:0] o_quo,
    output logic [nm_pkg::NUM_ENTRIES-1:0] o_neg,
    output logic [nm_pkg::NUM_ENTRIES-1:0] o_ovf
);
    import nm_pkg::*;

    localparam int XW = rem_width(DW, F);

    t_stage_ctl r_ctl;
    logic [3*DW+2:0] r_den;
    logic [NUM_ENTRIES-1:0][XW-1:0] r_rem;
    logic [NUM_ENTRIES-1:0][DW-1:0] r_quo;
    logic [NUM_ENTRIES-1:0] r_neg;
    logic [NUM_ENTRIES-1:0] r_ovf;

    logic [XW-1:0] w_dsh;
    logic [NUM_ENTRIES-1:0][XW-1:0] n_rem;
    logic [NUM_ENTRIES-1:0][DW-1:0] n_quo;

    assign o_en = !r_ctl.valid || i_en_down;

    // one restoring step per lane: try subtracting den << BIT
    always_comb begin
        w_dsh = XW'(i_den) << BIT;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            n_rem[i] = i_rem[i];
            n_quo[i] = i_quo[i];
            if (i_rem[i] >= w_dsh) begin
                n_rem[i]      = i_rem[i] - w_dsh;
                n_quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_neg <= i_neg;
            r_ovf <= i_ovf;
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_neg = r_neg;
    assign o_ovf = r_ovf;

endmodule

/* rtl/nm_out.sv */
module nm_out #(
    parameter int DW = 32,
    parameter int F  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  nm_pkg::t_stage_ctl i_ctl,
    output logic o_en,
    input  logic [3*DW+2:0] i_den,
    input  logic [nm_pkg::NUM_ENTRIES-1:0][nm_pkg::rem_width(DW, F)-1:0] i_rem,
    input  logic [nm_pkg::NUM_ENTRIES-1:0][DW-1:0] i_quo,
    input  logic [nm_pkg::NUM_ENTRIES-1:0] i_neg,
    input  logic [nm_pkg::NUM_ENTRIES-1:0] i_ovf,
    input  logic i_ready,
    output logic o_valid,
    output logic [nm_pkg::NUM_ENTRIES-1:0][DW-1:0] o_res,
    output logic o_singular
);
    import nm_pkg::*;

    localparam int XW = rem_width(DW, F);
    localparam logic [DW:0]   LIM     = {2'b00, {(DW-1){1'b1}}};
    localparam logic [DW:0]   NEG_LIM = {2'b01, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] ONE     = (F < DW - 1) ? (DW'(1) << F) : LIM[DW-1:0];

    logic r_valid;
    logic r_sing;
    logic [NUM_ENTRIES-1:0][DW-1:0] r_res;
    logic [NUM_ENTRIES-1:0][DW-1:0] n_res;
    logic [DW:0] w_mag;
    logic [DW:0] w_neg_mag;
    logic        w_up;

    assign o_en = !r_valid || i_ready;

    // round half away from zero on magnitude, then saturate and apply sign; a singular item gives the identity
    always_comb begin
        w_mag     = '0;
        w_neg_mag = '0;
        w_up      = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            w_up  = ({1'b0, i_rem[i]} << 1) >= (XW+1)'(i_den);
            w_mag = (DW+1)'(i_quo[i]) + (DW+1)'(w_up);
            if (i_neg[i]) begin
                w_neg_mag = (i_ovf[i] || w_mag > NEG_LIM) ? NEG_LIM : w_mag;
                n_res[i]  = DW'(~w_neg_mag + 1'b1);
            end else begin
                n_res[i] = (i_ovf[i] || w_mag > LIM) ? LIM[DW-1:0] : w_mag[DW-1:0];
            end
            if (i_ctl.singular) begin
                n_res[i] = ((i % 4) == 0) ? ONE : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_res  <= n_res;
            r_sing <= i_ctl.singular;
        end
    end

    assign o_valid    = r_valid;
    assign o_res      = r_res;
    assign o_singular = r_sing;

endmodule

/* rtl/normal_matrix_3x3.sv */
// Normal matrix (inverse transpose) of a 3x3 transform, signed fixed point.
//
// Input channel i_in: nine entries in column-major order, DATA_WIDTH bits with
// FRAC_BITS fraction bits. Output channel o_out: the nine entries of the
// inverse transpose in the same order and format, plus a singular flag. A
// transaction moves when valid and ready are both high.
// The APB port holds det_threshold at byte address 0; a matrix whose
// determinant magnitude is at or below it gives the identity with singular set.
//
// The pipeline has a front part of products, cofactors and determinant, a row of
// divider cells that each settle one quotient bit and all work on the nine entries
// at once, and a final rounding and saturation step into the output register.
// Throughput is one matrix per cycle while the receiver does not stall.
// Every stage has its own valid bit, so bubbles close up when the receiver
// stalls and the block keeps taking transactions until every stage is full.
// Reset clears all valid bits and sets det_threshold to zero; no pipeline
// contents survive it.
module normal_matrix_3x3 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nm_in_if.sink   i_in,
    nm_out_if.source o_out,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [nm_pkg::PADDR_W-1:0] paddr,
    input  logic [nm_pkg::PDATA_W-1:0] pwdata,
    output logic [nm_pkg::PDATA_W-1:0] prdata,
    output logic pready
);
    import nm_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int DTW = 3 * DW + 3;
    localparam int XW  = rem_width(DW, FRAC_BITS);
    localparam logic [DW-1:0] ONE = (FRAC_BITS < DW - 1) ? (DW'(1) << FRAC_BITS)
                                                          : {1'b0, {(DW-1){1'b1}}};

    logic [THR_W-1:0] r_det_threshold;
    logic             w_wr;

    logic [NUM_ENTRIES-1:0][DW-1:0] w_mat;
    logic [NUM_ENTRIES-1:0][DW-1:0] w_res;

    t_stage_ctl w_ctl [0:DW];
    logic [DTW-1:0] w_den [0:DW];
    logic [NUM_ENTRIES-1:0][XW-1:0] w_rem [0:DW];
    logic [NUM_ENTRIES-1:0][DW-1:0] w_quo [0:DW];
    logic [NUM_ENTRIES-1:0] w_neg [0:DW];
    logic [NUM_ENTRIES-1:0] w_ovf [0:DW];
    logic [DW:0] w_en;

    // config register
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_DET_THRESHOLD);
    assign prdata = (paddr[2] == REG_DET_THRESHOLD) ? PDATA_W'(r_det_threshold) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_threshold <= '0;
        end else if (w_wr) begin
            r_det_threshold <= pwdata[THR_W-1:0];
        end
    end

    assign w_mat[0] = i_in.col0_row0;
    assign w_mat[1] = i_in.col0_row1;
    assign w_mat[2] = i_in.col0_row2;
    assign w_mat[3] = i_in.col1_row0;
    assign w_mat[4] = i_in.col1_row1;
    assign w_mat[5] = i_in.col1_row2;
    assign w_mat[6] = i_in.col2_row0;
    assign w_mat[7] = i_in.col2_row1;
    assign w_mat[8] = i_in.col2_row2;

    nm_front #(.DW(DW), .F(FRAC_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .o_ready   (i_in.ready),
        .i_mat     (w_mat),
        .i_thr     (r_det_threshold),
        .i_en_down (w_en[0]),
        .o_ctl     (w_ctl[0]),
        .o_den     (w_den[0]),
        .o_rem     (w_rem[0]),
        .o_neg     (w_neg[0]),
        .o_ovf     (w_ovf[0])
    );

    assign w_quo[0] = '0;

    genvar gk;
    generate
        for (gk = 0; gk < DW; gk++) begin : g_cell
            nm_div_cell #(.DW(DW), .F(FRAC_BITS), .BIT(DW - 1 - gk)) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl[gk]),
                .i_en_down (w_en[gk+1]),
                .o_en      (w_en[gk]),
                .i_den     (w_den[gk]),
                .i_rem     (w_rem[gk]),
                .i_quo     (w_quo[gk]),
                .i_neg     (w_neg[gk]),
                .i_ovf     (w_ovf[gk]),
                .o_ctl     (w_ctl[gk+1]),
                .o_den     (w_den[gk+1]),
                .o_rem     (w_rem[gk+1]),
                .o_quo     (w_quo[gk+1]),
                .o_neg     (w_neg[gk+1]),
                .o_ovf     (w_ovf[gk+1])
            );
        end
    endgenerate

    nm_out #(.DW(DW), .F(FRAC_BITS)) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl[DW]),
        .o_en       (w_en[DW]),
        .i_den      (w_den[DW]),
        .i_rem      (w_rem[DW]),
        .i_quo      (w_quo[DW]),
        .i_neg      (w_neg[DW]),
        .i_ovf      (w_ovf[DW]),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_res      (w_res),
        .o_singular (o_out.singular)
    );

    // lanes hold cofactors in row-major order; transpose onto column-major outputs
    assign o_out.out_c0_r0 = w_res[0];
    assign o_out.out_c0_r1 = w_res[3];
    assign o_out.out_c0_r2 = w_res[6];
    assign o_out.out_c1_r0 = w_res[1];
    assign o_out.out_c1_r1 = w_res[4];
    assign o_out.out_c1_r2 = w_res[7];
    assign o_out.out_c2_r0 = w_res[2];
    assign o_out.out_c2_r1 = w_res[5];
    assign o_out.out_c2_r2 = w_res[8];

    // input backpressure only comes from a full pipeline behind a stalled output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

    a_singular_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |->
            (w_res[0] == ONE && w_res[4] == ONE && w_res[8] == ONE &&
             w_res[1] == '0 && w_res[2] == '0 && w_res[3] == '0 &&
             w_res[5] == '0 && w_res[6] == '0 && w_res[7] == '0))
        else $error("singular result is not the identity");

    a_threshold_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (r_det_threshold == $past(pwdata[THR_W-1:0])))
        else $error("threshold write lost");

endmodule
